### sv/drpk_pkg.sv
// Shared types and constants for the DER RSA private key parser.
`default_nettype none

package drpk_pkg;

    // Input command codes
    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_END     = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_PARSING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // DER constants
    localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
    localparam logic [7:0] TAG_INTEGER   = 8'h02;
    localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
    localparam logic [7:0] LEN_LONG_MAX  = 8'h82;

    // Key slots: version, n, e, d, p, q, dp, dq, qinv
    localparam logic [3:0] SLOT_COUNT = 4'd9;

    // One input beat
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] byte_value;
        logic [3:0] field_select;
        logic [6:0] byte_index;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] fields_parsed;
        logic [7:0] read_byte;
    } out_item_t;

    // Classified operation held in the queue
    typedef enum logic [3:0] {
        OP_DATA    = 4'b0001,
        OP_END     = 4'b0010,
        OP_READ    = 4'b0100,
        OP_RESTART = 4'b1000
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_value;
        logic [3:0] field_select;
        logic [6:0] byte_index;
    } queue_entry_t;

    // Parse phase
    typedef enum logic [6:0] {
        PH_SEQ_TAG = 7'b0000001,
        PH_SEQ_LEN = 7'b0000010,
        PH_INT_TAG = 7'b0000100,
        PH_INT_LEN = 7'b0001000,
        PH_CONTENT = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    // Back-end sequencer
    typedef enum logic [3:0] {
        CTL_CLEAR = 4'b0001,
        CTL_IDLE  = 4'b0010,
        CTL_READ  = 4'b0100,
        CTL_FILL  = 4'b1000
    } ctl_t;

    function automatic logic [1:0] status_of(input phase_t ph);
        logic [1:0] st;
        st = ST_PARSING;
        if (ph == PH_DONE) begin
            st = ST_DONE;
        end else if (ph == PH_ERROR) begin
            st = ST_ERROR;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

### sv/drpk_front.sv
// Front end: accepts input beats, classifies the command and queues the work.
`default_nettype none

module drpk_front
    import drpk_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire in_item_t     s_data,
    input  wire logic         busy,
    output logic              q_valid,
    output queue_entry_t      q_data,
    input  wire logic         q_pop
);

    localparam int QUEUE_DEPTH = 2;

    queue_entry_t entry_reg [QUEUE_DEPTH];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push;
    queue_entry_t classified;

    // Classify the incoming command
    always_comb begin
        classified.byte_value   = s_data.byte_value;
        classified.field_select = s_data.field_select;
        classified.byte_index   = s_data.byte_index;
        case (s_data.cmd)
            CMD_DATA: begin
                classified.op = OP_DATA;
            end
            CMD_END: begin
                classified.op = OP_END;
            end
            CMD_READ: begin
                classified.op = OP_READ;
            end
            CMD_RESTART: begin
                classified.op = OP_RESTART;
            end
            default: begin
                classified.op = OP_RESTART;
            end
        endcase
    end

    // Hold off input while the queue is full or the store is being cleared
    assign s_ready = (count_reg != 2'(QUEUE_DEPTH)) && !busy;
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the queued entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule

`default_nettype wire

### sv/drpk_store.sv
// Key store: single write port, one registered read port.
`default_nettype none

module drpk_store #(
    parameter int DEPTH = 584
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [7:0]               wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]                    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/drpk_back.sv
// Back end: DER parse sequencer, zero fill and clearing sweeps, result register.
`default_nettype none

module drpk_back
    import drpk_pkg::*;
#(
    parameter int LONG_FIELD_BYTES  = 128,
    parameter int HALF_FIELD_BYTES  = 64,
    parameter int SHORT_FIELD_BYTES = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire queue_entry_t q_data,
    output logic              q_pop,
    output logic              busy,
    output logic              m_valid,
    input  wire logic         m_ready,
    output out_item_t         m_data
);

    localparam int STORE_BYTES = 2 * SHORT_FIELD_BYTES + 2 * LONG_FIELD_BYTES
                               + 5 * HALF_FIELD_BYTES;
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int B1 = SHORT_FIELD_BYTES;
    localparam int B2 = B1 + LONG_FIELD_BYTES;
    localparam int B3 = B2 + SHORT_FIELD_BYTES;
    localparam int B4 = B3 + LONG_FIELD_BYTES;
    localparam int B5 = B4 + HALF_FIELD_BYTES;
    localparam int B6 = B5 + HALF_FIELD_BYTES;
    localparam int B7 = B6 + HALF_FIELD_BYTES;
    localparam int B8 = B7 + HALF_FIELD_BYTES;

    function automatic logic [15:0] size_of(input logic [3:0] f);
        logic [15:0] s;
        case (f)
            4'd0, 4'd2: s = 16'(SHORT_FIELD_BYTES);
            4'd1, 4'd3: s = 16'(LONG_FIELD_BYTES);
            default:    s = 16'(HALF_FIELD_BYTES);
        endcase
        return s;
    endfunction

    function automatic logic [ADDR_W-1:0] base_of(input logic [3:0] f);
        logic [ADDR_W-1:0] b;
        case (f)
            4'd1:    b = ADDR_W'(B1);
            4'd2:    b = ADDR_W'(B2);
            4'd3:    b = ADDR_W'(B3);
            4'd4:    b = ADDR_W'(B4);
            4'd5:    b = ADDR_W'(B5);
            4'd6:    b = ADDR_W'(B6);
            4'd7:    b = ADDR_W'(B7);
            4'd8:    b = ADDR_W'(B8);
            default: b = '0;
        endcase
        return b;
    endfunction

    ctl_t              ctl_reg, ctl_next;
    phase_t            phase_reg, phase_next;
    logic [3:0]        field_reg, field_next;
    logic [1:0]        left_reg, left_next;
    logic [15:0]       accum_reg, accum_next;
    logic [15:0]       pos_reg, pos_next;
    logic              lead_reg, lead_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] fill_last_reg, fill_last_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              out_free;
    logic              start;
    logic              out_load;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic [7:0]        b;
    logic [15:0]       cur_size;
    logic [ADDR_W-1:0] cur_base;
    logic              f_ok;
    logic              len_done;
    logic [15:0]       len_val;
    logic [15:0]       wpos;
    logic [15:0]       pos_inc;
    logic              do_finish;
    logic [15:0]       fin;
    logic              go_fill;

    assign out_free = !m_valid_reg || m_ready;
    assign start    = (ctl_reg == CTL_IDLE) && q_valid && out_free;
    assign q_pop    = start;
    assign busy     = (ctl_reg == CTL_CLEAR);
    assign b        = q_data.byte_value;
    assign cur_size = size_of(field_reg);
    assign cur_base = base_of(field_reg);
    assign f_ok     = field_reg < SLOT_COUNT;
    assign wpos     = accum_reg - 16'd1 - pos_reg;
    assign pos_inc  = pos_reg + 16'd1;

    drpk_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequence the parse, sweeps and reads
    always_comb begin
        ctl_next       = ctl_reg;
        phase_next     = phase_reg;
        field_next     = field_reg;
        left_next      = left_reg;
        accum_next     = accum_reg;
        pos_next       = pos_reg;
        lead_next      = lead_reg;
        fill_addr_next = fill_addr_reg;
        fill_last_next = fill_last_reg;
        rd_ok_next     = rd_ok_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_addr_reg;
        mem_wdata      = 8'h00;
        mem_re         = 1'b0;
        mem_raddr      = base_of(q_data.field_select) + ADDR_W'(q_data.byte_index);
        out_load       = 1'b0;
        m_data_next    = m_data_reg;
        len_done       = 1'b0;
        len_val        = accum_reg;
        do_finish      = 1'b0;
        fin            = 16'd0;
        go_fill        = 1'b0;

        case (ctl_reg)
            CTL_CLEAR: begin
                mem_we         = 1'b1;
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                if (fill_addr_reg == fill_last_reg) begin
                    ctl_next = CTL_IDLE;
                end
            end
            CTL_FILL: begin
                mem_we         = 1'b1;
                fill_addr_next = fill_addr_reg + ADDR_W'(1);
                if (fill_addr_reg == fill_last_reg) begin
                    ctl_next    = CTL_IDLE;
                    out_load    = 1'b1;
                    m_data_next = '{status_of(phase_reg), field_reg, 8'h00};
                end
            end
            CTL_READ: begin
                ctl_next    = CTL_IDLE;
                out_load    = 1'b1;
                m_data_next = '{status_of(phase_reg), field_reg,
                                rd_ok_reg ? mem_rdata : 8'h00};
            end
            CTL_IDLE: begin
                if (start) begin
                    case (q_data.op)
                        OP_DATA: begin
                            case (phase_reg)
                                PH_SEQ_TAG: begin
                                    if (b == TAG_SEQUENCE) begin
                                        phase_next = PH_SEQ_LEN;
                                        left_next  = 2'd0;
                                    end else begin
                                        phase_next = PH_ERROR;
                                    end
                                end
                                PH_INT_TAG: begin
                                    if (b == TAG_INTEGER) begin
                                        phase_next = PH_INT_LEN;
                                        left_next  = 2'd0;
                                    end else begin
                                        phase_next = PH_ERROR;
                                    end
                                end
                                PH_SEQ_LEN, PH_INT_LEN: begin
                                    // Gather short or long form length
                                    if (left_reg == 2'd0) begin
                                        if (b < LEN_LONG_FLAG) begin
                                            len_val    = {8'h00, b};
                                            accum_next = len_val;
                                            len_done   = 1'b1;
                                        end else if (b == LEN_LONG_FLAG
                                                     || b > LEN_LONG_MAX) begin
                                            phase_next = PH_ERROR;
                                        end else begin
                                            left_next  = b[1:0];
                                            accum_next = 16'd0;
                                        end
                                    end else begin
                                        len_val    = {accum_reg[7:0], b};
                                        accum_next = len_val;
                                        left_next  = left_reg - 2'd1;
                                        len_done   = (left_reg == 2'd1);
                                    end
                                    if (len_done) begin
                                        if (phase_reg == PH_SEQ_LEN) begin
                                            phase_next = PH_INT_TAG;
                                            left_next  = 2'd0;
                                        end else if (!f_ok || {1'b0, len_val}
                                                     > {1'b0, cur_size} + 17'd1) begin
                                            phase_next = PH_ERROR;
                                        end else begin
                                            pos_next  = 16'd0;
                                            lead_next = 1'b0;
                                            if (len_val == 16'd0) begin
                                                do_finish = 1'b1;
                                                fin       = 16'd0;
                                            end else begin
                                                phase_next = PH_CONTENT;
                                            end
                                        end
                                    end
                                end
                                PH_CONTENT: begin
                                    // Store content bytes in reverse order
                                    if (!f_ok || pos_reg >= accum_reg) begin
                                        phase_next = PH_ERROR;
                                    end else if (pos_reg == 16'd0 && b == 8'h00) begin
                                        lead_next = 1'b1;
                                        pos_next  = pos_inc;
                                        if (pos_inc == accum_reg) begin
                                            do_finish = 1'b1;
                                            fin       = accum_reg - 16'd1;
                                        end
                                    end else if (wpos >= cur_size) begin
                                        phase_next = PH_ERROR;
                                    end else begin
                                        mem_we    = 1'b1;
                                        mem_waddr = cur_base + ADDR_W'(wpos);
                                        mem_wdata = b;
                                        pos_next  = pos_inc;
                                        if (pos_inc == accum_reg) begin
                                            do_finish = 1'b1;
                                            fin       = accum_reg - {15'd0, lead_reg};
                                        end
                                    end
                                end
                                default: begin
                                end
                            endcase
                            // Close the integer and set up the zero fill
                            if (do_finish) begin
                                field_next = field_reg + 4'd1;
                                left_next  = 2'd0;
                                phase_next = (field_reg + 4'd1 >= SLOT_COUNT)
                                             ? PH_DONE : PH_INT_TAG;
                                if (fin < cur_size) begin
                                    go_fill        = 1'b1;
                                    fill_addr_next = cur_base + ADDR_W'(fin);
                                    fill_last_next = cur_base
                                                     + ADDR_W'(cur_size - 16'd1);
                                end
                            end
                            if (go_fill) begin
                                ctl_next = CTL_FILL;
                            end else begin
                                out_load    = 1'b1;
                                m_data_next = '{status_of(phase_next), field_next, 8'h00};
                            end
                        end
                        OP_END: begin
                            if (phase_reg != PH_DONE && phase_reg != PH_ERROR) begin
                                phase_next = PH_ERROR;
                            end
                            out_load    = 1'b1;
                            m_data_next = '{status_of(phase_next), field_reg, 8'h00};
                        end
                        OP_READ: begin
                            mem_re     = 1'b1;
                            rd_ok_next = (q_data.field_select < SLOT_COUNT)
                                && (16'(q_data.byte_index) < size_of(q_data.field_select));
                            ctl_next   = CTL_READ;
                        end
                        OP_RESTART: begin
                            phase_next  = PH_SEQ_TAG;
                            field_next  = 4'd0;
                            left_next   = 2'd0;
                            accum_next  = 16'd0;
                            pos_next    = 16'd0;
                            lead_next   = 1'b0;
                            out_load    = 1'b1;
                            m_data_next = '{ST_PARSING, 4'd0, 8'h00};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    // Hold the result until the beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg       <= CTL_CLEAR;
            phase_reg     <= PH_SEQ_TAG;
            field_reg     <= 4'd0;
            left_reg      <= 2'd0;
            accum_reg     <= 16'd0;
            pos_reg       <= 16'd0;
            lead_reg      <= 1'b0;
            fill_addr_reg <= '0;
            fill_last_reg <= ADDR_W'(STORE_BYTES - 1);
            m_valid_reg   <= 1'b0;
        end else begin
            ctl_reg       <= ctl_next;
            phase_reg     <= phase_next;
            field_reg     <= field_next;
            left_reg      <= left_next;
            accum_reg     <= accum_next;
            pos_reg       <= pos_next;
            lead_reg      <= lead_next;
            fill_addr_reg <= fill_addr_next;
            fill_last_reg <= fill_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_ok_reg  <= rd_ok_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg == CTL_CLEAR) |-> !q_pop)
        else $error("item taken during clearing sweep");

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg == CTL_FILL || ctl_reg == CTL_CLEAR) |-> fill_addr_reg <= fill_last_reg)
        else $error("sweep address past its end");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");

    a_done_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) == (field_reg == SLOT_COUNT))
        else $error("completion and field count disagree");

endmodule

`default_nettype wire

### sv/der_rsa_private_key_parser_top.sv
// DER RSA private key parser, top level.
// Takes one decoded DER byte or command per beat and returns one result beat for each.
// After reset a clearing sweep writes zero to all 2*SHORT+2*LONG+5*HALF store bytes
// (584 at the defaults), one byte a cycle, with s_ready low. An item then passes
// the two-entry front queue to the back end; a read also passes a read state (registered
// store read port). The byte that completes an integer (its last content byte, or the
// length byte of an empty one) then starts a zero fill of the slot bytes still unwritten,
// and the single store write port clears them one byte a cycle.
`default_nettype none

module der_rsa_private_key_parser_top
    import drpk_pkg::*;
#(
    parameter int LONG_FIELD_BYTES  = 128,
    parameter int HALF_FIELD_BYTES  = 64,
    parameter int SHORT_FIELD_BYTES = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic         q_valid;
    queue_entry_t q_data;
    logic         q_pop;
    logic         busy;

    // Accept and classify
    drpk_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .busy    (busy),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    // Parse, store and answer
    drpk_back #(
        .LONG_FIELD_BYTES  (LONG_FIELD_BYTES),
        .HALF_FIELD_BYTES  (HALF_FIELD_BYTES),
        .SHORT_FIELD_BYTES (SHORT_FIELD_BYTES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .busy    (busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### dv/key_parse_checker.sv
// Result checker for the DER RSA private key parser: tracks the parse and compares result beats.
`timescale 1ns / 1ps

module key_parse_checker
    import drpk_pkg::*;
#(
    parameter int LONG_FIELD_BYTES  = 128,
    parameter int HALF_FIELD_BYTES  = 64,
    parameter int SHORT_FIELD_BYTES = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    output int             fail_count,
    output int             outstanding,
    output int             results_checked,
    output int             keys_completed,
    output int             error_stops
);

    localparam int STORE_BYTES = 2 * SHORT_FIELD_BYTES + 2 * LONG_FIELD_BYTES
                               + 5 * HALF_FIELD_BYTES;

    phase_t      parse_phase;
    logic [3:0]  key_field;
    logic [1:0]  len_bytes_due;
    logic [15:0] len_value;
    logic [15:0] content_count;
    logic        zero_dropped;
    logic [7:0]  key_bytes [STORE_BYTES];
    out_item_t   expected_results [$];
    int          fail_tally;
    int          checked_tally;
    int          done_tally;
    int          error_tally;

    function automatic int slot_bytes(input int f);
        case (f)
            0, 2:    return SHORT_FIELD_BYTES;
            1, 3:    return LONG_FIELD_BYTES;
            default: return HALF_FIELD_BYTES;
        endcase
    endfunction

    // Slots lie back to back: version, n, e, d, p, q, dp, dq, qinv
    function automatic int slot_origin(input int f);
        int base;
        base = 0;
        for (int k = 0; k < f && k < SLOT_COUNT; k++) begin
            base += slot_bytes(k);
        end
        return base;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        fail_tally++;
    endtask

    task automatic clear_parse();
        parse_phase   = PH_SEQ_TAG;
        key_field     = '0;
        len_bytes_due = '0;
        len_value     = '0;
        content_count = '0;
        zero_dropped  = 1'b0;
    endtask

    // Zero-fill the slot above the stored bytes and move to the next integer
    task automatic close_integer();
        int fill_from;
        if (key_field >= SLOT_COUNT) begin
            parse_phase = PH_ERROR;
            return;
        end
        fill_from = int'(len_value) - int'(zero_dropped);
        for (int k = fill_from; k < slot_bytes(key_field); k++) begin
            key_bytes[slot_origin(key_field) + k] = 8'h00;
        end
        key_field     = key_field + 4'd1;
        len_bytes_due = '0;
        parse_phase   = (key_field >= SLOT_COUNT) ? PH_DONE : PH_INT_TAG;
    endtask

    task automatic length_done();
        if (parse_phase == PH_SEQ_LEN) begin
            // sequence length is parsed and then ignored
            parse_phase   = PH_INT_TAG;
            len_bytes_due = '0;
            return;
        end
        if (key_field >= SLOT_COUNT || int'(len_value) > slot_bytes(key_field) + 1) begin
            parse_phase = PH_ERROR;
            return;
        end
        content_count = '0;
        zero_dropped  = 1'b0;
        if (len_value == 0) begin
            close_integer();
        end else begin
            parse_phase = PH_CONTENT;
        end
    endtask

    task automatic take_length(input logic [7:0] b);
        if (len_bytes_due == 0) begin
            if (b < LEN_LONG_FLAG) begin
                len_value = {8'h00, b};
                length_done();
            end else if (b == LEN_LONG_FLAG || b > LEN_LONG_MAX) begin
                // indefinite form or more than two length bytes
                parse_phase = PH_ERROR;
            end else begin
                len_bytes_due = b[1:0];
                len_value     = '0;
            end
        end else begin
            len_value     = {len_value[7:0], b};
            len_bytes_due = len_bytes_due - 2'd1;
            if (len_bytes_due == 0) begin
                length_done();
            end
        end
    endtask

    // Store content reversed, dropping one leading zero byte
    task automatic take_content(input logic [7:0] b);
        int pos;
        if (key_field >= SLOT_COUNT || content_count >= len_value) begin
            parse_phase = PH_ERROR;
            return;
        end
        if (content_count == 0 && b == 8'h00) begin
            zero_dropped = 1'b1;
        end else begin
            pos = int'(len_value) - 1 - int'(content_count);
            if (pos >= slot_bytes(key_field)) begin
                parse_phase = PH_ERROR;
                return;
            end
            key_bytes[slot_origin(key_field) + pos] = b;
        end
        content_count = content_count + 16'd1;
        if (content_count == len_value) begin
            close_integer();
        end
    endtask

    task automatic feed_byte(input logic [7:0] b);
        case (parse_phase)
            PH_SEQ_TAG: begin
                if (b == TAG_SEQUENCE) begin
                    parse_phase   = PH_SEQ_LEN;
                    len_bytes_due = '0;
                end else begin
                    parse_phase = PH_ERROR;
                end
            end
            PH_INT_TAG: begin
                if (b == TAG_INTEGER) begin
                    parse_phase   = PH_INT_LEN;
                    len_bytes_due = '0;
                end else begin
                    parse_phase = PH_ERROR;
                end
            end
            PH_SEQ_LEN, PH_INT_LEN: take_length(b);
            PH_CONTENT:             take_content(b);
            default: ;
        endcase
    endtask

    // Apply one input beat and work out the result beat it causes
    task automatic advance_parser(input in_item_t it, output out_item_t res);
        logic [7:0] rd;
        rd = 8'h00;
        case (it.cmd)
            CMD_DATA: feed_byte(it.byte_value);
            CMD_END: begin
                if (parse_phase != PH_DONE && parse_phase != PH_ERROR) begin
                    parse_phase = PH_ERROR;
                end
            end
            CMD_READ: begin
                if (it.field_select < SLOT_COUNT
                        && int'(it.byte_index) < slot_bytes(it.field_select)) begin
                    rd = key_bytes[slot_origin(it.field_select) + int'(it.byte_index)];
                end
            end
            default: clear_parse();
        endcase
        if (parse_phase == PH_DONE) begin
            res.status = ST_DONE;
        end else if (parse_phase == PH_ERROR) begin
            res.status = ST_ERROR;
        end else begin
            res.status = ST_PARSING;
        end
        res.fields_parsed = key_field;
        res.read_byte     = rd;
    endtask

    // Predict on each accepted input beat, compare each accepted result beat
    always @(posedge aclk) begin : watch
        out_item_t predicted;
        out_item_t wanted;
        phase_t    phase_was;
        if (!aresetn) begin
            clear_parse();
            foreach (key_bytes[i]) begin
                key_bytes[i] = 8'h00;
            end
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                phase_was = parse_phase;
                advance_parser(s_data, predicted);
                expected_results.push_back(predicted);
                if (parse_phase == PH_DONE && phase_was != PH_DONE) begin
                    done_tally++;
                end
                if (parse_phase == PH_ERROR && phase_was != PH_ERROR) begin
                    error_tally++;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", int'(m_data), 0);
                end else begin
                    wanted = expected_results.pop_front();
                    if (m_data.status !== wanted.status) begin
                        report_mismatch("status", m_data.status, wanted.status);
                    end
                    if (m_data.fields_parsed !== wanted.fields_parsed) begin
                        report_mismatch("fields_parsed", m_data.fields_parsed,
                                        wanted.fields_parsed);
                    end
                    if (m_data.read_byte !== wanted.read_byte) begin
                        report_mismatch("read_byte", m_data.read_byte, wanted.read_byte);
                    end
                    checked_tally++;
                end
            end
        end
        fail_count      <= fail_tally;
        outstanding     <= expected_results.size();
        results_checked <= checked_tally;
        keys_completed  <= done_tally;
        error_stops     <= error_tally;
    end

endmodule

### dv/testbench.sv
// Testbench top for the DER RSA private key parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import drpk_pkg::*;

    localparam int LONG_BYTES   = 128;
    localparam int HALF_BYTES   = 64;
    localparam int SHORT_BYTES  = 4;
    localparam int BEATS_WANTED = 1850;
    localparam int DRAIN_CYCLES = 300;
    localparam int TIMEOUT_NS   = 10_000_000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int        fail_count;
    int        outstanding;
    int        results_checked;
    int        keys_completed;
    int        error_stops;

    in_item_t   beat_plan [$];
    logic [7:0] der_stream [$];
    int         len_spots [$];
    int         tag_spots [$];
    int         counted_beats;
    int         read_beats;
    bit         tx_rush;

    always #5 aclk = ~aclk;

    der_rsa_private_key_parser_top #(
        .LONG_FIELD_BYTES  (LONG_BYTES),
        .HALF_FIELD_BYTES  (HALF_BYTES),
        .SHORT_FIELD_BYTES (SHORT_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    key_parse_checker #(
        .LONG_FIELD_BYTES  (LONG_BYTES),
        .HALF_FIELD_BYTES  (HALF_BYTES),
        .SHORT_FIELD_BYTES (SHORT_BYTES)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .keys_completed  (keys_completed),
        .error_stops     (error_stops)
    );

    function automatic int slot_span(input int f);
        case (f)
            0, 2:    return SHORT_BYTES;
            1, 3:    return LONG_BYTES;
            default: return HALF_BYTES;
        endcase
    endfunction

    // Beat with random filler in the fields the command does not use
    function automatic in_item_t loose_beat(input logic [1:0] cmd);
        in_item_t it;
        it.cmd          = cmd;
        it.byte_value   = 8'($urandom);
        it.field_select = 4'($urandom);
        it.byte_index   = 7'($urandom);
        return it;
    endfunction

    task automatic plan_beat(input in_item_t it, input bit tally);
        beat_plan.push_back(it);
        if (tally) begin
            counted_beats++;
        end
    endtask

    task automatic plan_data(input logic [7:0] b);
        in_item_t it;
        it = loose_beat(CMD_DATA);
        it.byte_value = b;
        plan_beat(it, 1'b1);
    endtask

    task automatic plan_cmd(input logic [1:0] cmd);
        plan_beat(loose_beat(cmd), 1'b1);
    endtask

    task automatic plan_read(input logic [3:0] fs, input logic [6:0] bi);
        in_item_t it;
        it = loose_beat(CMD_READ);
        it.field_select = fs;
        it.byte_index   = bi;
        plan_beat(it, 1'b1);
        read_beats++;
    endtask

    // Mostly in-range reads, now and then anywhere in the field ranges
    task automatic plan_any_read();
        int fs;
        fs = $urandom_range(0, 8);
        if ($urandom_range(0, 7) == 0) begin
            plan_read(4'($urandom), 7'($urandom));
        end else begin
            plan_read(4'(fs), 7'($urandom_range(0, slot_span(fs) - 1)));
        end
    endtask

    // Encode a length in short form or with one or two length bytes
    task automatic add_length(input int len);
        int pick;
        pick = $urandom_range(0, 3);
        len_spots.push_back(der_stream.size());
        if (len < 128 && pick < 2) begin
            der_stream.push_back(8'(len));
        end else if (len < 256 && pick < 3) begin
            der_stream.push_back(LEN_LONG_FLAG + 8'd1);
            der_stream.push_back(8'(len));
        end else begin
            der_stream.push_back(LEN_LONG_MAX);
            der_stream.push_back(8'(len >> 8));
            der_stream.push_back(8'(len));
        end
    endtask

    // One INTEGER; small lengths mostly, full slots now and then, too long if oversize
    task automatic add_integer(input int f, input bit oversize);
        int span;
        int len;
        int body;
        bit lead_zero;
        span      = slot_span(f);
        lead_zero = 1'b0;
        if (oversize) begin
            if ($urandom_range(0, 1) == 1) begin
                len = span + 1;
            end else begin
                len       = span + 2 + $urandom_range(0, 30);
                lead_zero = 1'($urandom_range(0, 1));
            end
        end else begin
            case ($urandom_range(0, 15))
                0: len = 0;
                1: begin
                    len       = span;
                    lead_zero = 1'($urandom_range(0, 1));
                end
                2: begin
                    len       = span + 1;
                    lead_zero = 1'b1;
                end
                default: begin
                    len       = $urandom_range(1, (span < 8) ? span : 8);
                    lead_zero = ($urandom_range(0, 3) == 0);
                end
            endcase
        end
        tag_spots.push_back(der_stream.size());
        der_stream.push_back(TAG_INTEGER);
        add_length(len);
        // past an oversize length the bytes are dead weight, so keep few
        body = (oversize && len > 3) ? 3 : len;
        for (int i = 0; i < body; i++) begin
            if (i == 0) begin
                der_stream.push_back(lead_zero ? 8'h00 : 8'($urandom_range(1, 255)));
            end else begin
                der_stream.push_back(8'($urandom));
            end
        end
    endtask

    // One key: mostly well-formed, else broken at one chosen spot
    task automatic plan_session();
        bit broken;
        int twist;
        int bad_field;
        int k;
        broken    = ($urandom_range(0, 3) == 0);
        twist     = $urandom_range(0, 5);
        bad_field = $urandom_range(0, 8);
        k         = -1;
        der_stream.delete();
        len_spots.delete();
        tag_spots.delete();
        tag_spots.push_back(0);
        der_stream.push_back(TAG_SEQUENCE);
        add_length($urandom_range(0, 700));
        for (int f = 0; f < SLOT_COUNT; f++) begin
            add_integer(f, broken && twist == 0 && f == bad_field);
        end
        if (broken) begin
            case (twist)
                1: begin
                    k = tag_spots[$urandom_range(0, tag_spots.size() - 1)];
                    der_stream[k] = 8'($urandom);
                end
                2: begin
                    k = len_spots[$urandom_range(0, len_spots.size() - 1)];
                    der_stream[k] = LEN_LONG_FLAG;
                end
                3: begin
                    k = len_spots[$urandom_range(0, len_spots.size() - 1)];
                    der_stream[k] = 8'($urandom_range(8'h83, 8'hFF));
                end
                4, 5: k = $urandom_range(0, der_stream.size() - 1);
                default: ;
            endcase
        end
        plan_cmd(CMD_RESTART);
        foreach (der_stream[i]) begin
            if ($urandom_range(0, 9) == 0) begin
                plan_any_read();
            end
            if (i == k && twist == 4) begin
                plan_cmd(CMD_END);
            end
            if (i == k && twist == 5) begin
                plan_cmd(CMD_RESTART);
            end
            plan_data(der_stream[i]);
        end
        repeat ($urandom_range(0, 6)) plan_any_read();
        // bytes past the end of the key are ignored, so leave them out of the tally
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) plan_beat(loose_beat(CMD_DATA), 1'b0);
        end
        if ($urandom_range(0, 1) == 1) begin
            plan_cmd(CMD_END);
        end
    endtask

    // Drop valid for a random gap unless rushing, then hold it until the beat is taken
    task automatic send_beat(input in_item_t it);
        int gap;
        gap = tx_rush ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_plan();
        foreach (beat_plan[i]) begin
            send_beat(beat_plan[i]);
        end
        beat_plan.delete();
    endtask

    // Drop valid and wait until every expected result beat is back
    task automatic hold_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, with stretches of none
    initial begin : result_sink
        int stall;
        int left;
        bit rx_rush;
        rx_rush = 1'b0;
        left    = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (left == 0) begin
                rx_rush = ($urandom_range(0, 3) == 0);
                left    = $urandom_range(20, 80);
            end
            left--;
            stall = rx_rush ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding", outstanding);
        $display("der_rsa_private_key_parser_top test failed");
        $finish;
    end

    initial begin : stimulus
        int sessions;
        sessions      = 0;
        counted_beats = 0;
        read_beats    = 0;
        tx_rush       = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reads after reset, indefinite length, trailing byte, end of stream
        plan_read(4'd15, 7'd127);
        plan_read(4'd0, 7'd0);
        plan_data(TAG_SEQUENCE);
        plan_data(LEN_LONG_FLAG);
        plan_data(8'h55);
        plan_cmd(CMD_END);
        // restart, long-form sequence length, empty version
        plan_cmd(CMD_RESTART);
        plan_data(TAG_SEQUENCE);
        plan_data(LEN_LONG_FLAG + 8'd1);
        plan_data(8'h7F);
        plan_data(TAG_INTEGER);
        plan_data(8'h00);
        // n: non-minimal two-byte length, extreme content bytes
        plan_data(TAG_INTEGER);
        plan_data(LEN_LONG_MAX);
        plan_data(8'h00);
        plan_data(8'h02);
        plan_data(8'hFF);
        plan_data(8'h01);
        // e: slot size plus one with its leading zero dropped
        plan_data(TAG_INTEGER);
        plan_data(8'h05);
        plan_data(8'h00);
        plan_data(8'hDE);
        plan_data(8'hAD);
        plan_data(8'hBE);
        plan_data(8'hEF);
        plan_read(4'd2, 7'd3);
        plan_read(4'd2, 7'd4);
        plan_read(4'd1, 7'd1);
        plan_cmd(CMD_END);
        send_plan();
        hold_sender();

        // Random keys, now and then letting the result side drain fully
        while (counted_beats < BEATS_WANTED) begin
            tx_rush = ($urandom_range(0, 3) == 0);
            plan_session();
            send_plan();
            sessions++;
            if (sessions % 8 == 0) begin
                hold_sender();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d keys over %0d beats (%0d reads): %0d parsed through, %0d stopped",
                 sessions, counted_beats, read_beats, keys_completed, error_stops);
        $display("Checked %0d result beats, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("der_rsa_private_key_parser_top test passed");
        end else begin
            $display("der_rsa_private_key_parser_top test failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/drpk_pkg.sv
sv/drpk_front.sv
sv/drpk_store.sv
sv/drpk_back.sv
sv/der_rsa_private_key_parser_top.sv
dv/key_parse_checker.sv
dv/testbench.sv
